// ===== src/grid_polynomial_generator_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GRID_POLYNOMIAL_GENERATOR_CORE_DEFINES_SVH
`define GRID_POLYNOMIAL_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication under reset.
`define GPG_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication under reset.
`define GPG_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== src/gpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Grid polynomial generator package
// Shared types and Q16.16 arithmetic helpers.
// ---------------------------------------------------------------------------
package gpg_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_COEF_ZERO  = 3'd0;
    localparam logic [2:0] REG_COEF_ONE   = 3'd1;
    localparam logic [2:0] REG_COEF_TWO   = 3'd2;
    localparam logic [2:0] REG_COEF_THREE = 3'd3;
    localparam logic [2:0] REG_GRID_STEP  = 3'd4;
    localparam logic [2:0] REG_DEGREE     = 3'd5;
    localparam logic [2:0] REG_NODE_COUNT = 3'd6;
    localparam logic [2:0] REG_SHAPE_MODE = 3'd7;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    // A saturated value with its clip flag.
    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } sat_t;

    // Word handed along the divider chain.
    typedef struct packed {
        logic               recip;
        logic               neg;
        logic               zdiv;
        logic               sat;
        logic signed [31:0] pval;
        logic [31:0]        dv;
    } div_word_t;

    // Clip a wide value to the Q16.16 range.
    function automatic sat_t sat64(input logic signed [63:0] v);
        sat_t r;
        begin
            if (v > Q_MAX) begin
                r.val  = 32'sh7FFFFFFF;
                r.clip = 1'b1;
            end else if (v < Q_MIN) begin
                r.val  = 32'sh80000000;
                r.clip = 1'b1;
            end else begin
                r.val  = v[31:0];
                r.clip = 1'b0;
            end
            return r;
        end
    endfunction

    // Q16.16 product, floored and clipped.
    function automatic sat_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] pr;
        begin
            pr = 64'(a) * 64'(b);
            return sat64(pr >>> 16);
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/gpg_poly_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Polynomial front end
// Seven-stage pipeline from node index to the saturated polynomial value.
// ---------------------------------------------------------------------------
module gpg_poly_front #(
    parameter int MAX_NODES  = 65536,
    parameter int MAX_DEGREE = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_take,
    input  wire logic [15:0]         node_index,
    input  wire logic signed [31:0]  coef_zero,
    input  wire logic signed [31:0]  coef_one,
    input  wire logic signed [31:0]  coef_two,
    input  wire logic signed [31:0]  coef_three,
    input  wire logic [30:0]         grid_step,
    input  wire logic [1:0]          degree,
    input  wire logic [16:0]         node_count,
    input  wire logic [1:0]          shape_mode,
    output logic                     out_valid,
    output gpg_pkg::div_word_t       out_word
);

    localparam logic [16:0] MAX_N = 17'(MAX_NODES);
    localparam logic [1:0]  MAX_D = 2'(MAX_DEGREE);

    logic [16:0] n_eff;
    logic [16:0] offset;
    logic [1:0]  deg_eff;
    logic        use1, use2, use3;

    // Effective count, degree and centring offset.
    always_comb
    begin
        n_eff   = (node_count > MAX_N) ? MAX_N : node_count;
        deg_eff = (degree > MAX_D) ? MAX_D : degree;
        use1    = (deg_eff >= 2'd1);
        use2    = (deg_eff >= 2'd2);
        use3    = (deg_eff == 2'd3);
        case (shape_mode)
            2'd1, 2'd2: offset = n_eff >> 2;
            2'd3:       offset = n_eff >> 1;
            default:    offset = '0;
        endcase
    end

    logic               va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg;
    logic signed [17:0] d_reg;
    gpg_pkg::sat_t      x_b_reg, x2_c_reg, t1_c_reg, x3_d_reg, t2_d_reg, t3_e_reg;
    logic signed [31:0] x_c_reg;
    logic               f_c_reg, f_d_reg, f_e_reg, f_f_reg;
    logic signed [33:0] acc_d_reg, acc_e_reg, acc_f_reg;
    gpg_pkg::div_word_t word_g_reg;

    logic signed [49:0] dh;
    gpg_pkg::sat_t      x_next, p_next;
    gpg_pkg::div_word_t word_next;

    // Scaled abscissa and final clip of the sum.
    always_comb
    begin
        dh                = d_reg * $signed({1'b0, grid_step});
        x_next            = gpg_pkg::sat64(64'(dh));
        p_next            = gpg_pkg::sat64(64'(acc_f_reg));
        word_next.recip   = shape_mode[1];
        word_next.pval    = p_next.val;
        word_next.neg     = p_next.val[31];
        word_next.zdiv    = shape_mode[1] && (p_next.val == 32'sd0);
        word_next.sat     = f_f_reg | p_next.clip;
        word_next.dv      = p_next.val[31] ? (32'd0 - p_next.val) : p_next.val;
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_take;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
        end
    end

    // Pipeline data: at most one multiplier depth per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= $signed({2'b00, node_index}) - $signed({1'b0, offset});
            x_b_reg   <= x_next;
            x_c_reg   <= x_b_reg.val;
            x2_c_reg  <= gpg_pkg::qmul(x_b_reg.val, x_b_reg.val);
            t1_c_reg  <= gpg_pkg::qmul(coef_one, x_b_reg.val);
            f_c_reg   <= use1 & x_b_reg.clip;
            x3_d_reg  <= gpg_pkg::qmul(x2_c_reg.val, x_c_reg);
            t2_d_reg  <= gpg_pkg::qmul(coef_two, x2_c_reg.val);
            acc_d_reg <= 34'(coef_zero) + (use1 ? 34'(t1_c_reg.val) : 34'sd0);
            f_d_reg   <= f_c_reg | (use1 & t1_c_reg.clip) | (use2 & x2_c_reg.clip);
            t3_e_reg  <= gpg_pkg::qmul(coef_three, x3_d_reg.val);
            acc_e_reg <= acc_d_reg + (use2 ? 34'(t2_d_reg.val) : 34'sd0);
            f_e_reg   <= f_d_reg | (use2 & t2_d_reg.clip) | (use3 & x3_d_reg.clip);
            acc_f_reg <= acc_e_reg + (use3 ? 34'(t3_e_reg.val) : 34'sd0);
            f_f_reg   <= f_e_reg | (use3 & t3_e_reg.clip);
            word_g_reg <= word_next;
        end
    end

    assign out_valid = vg_reg;
    assign out_word  = word_g_reg;

endmodule
`default_nettype wire

// ===== src/gpg_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Divider cell
// One restoring step of the reciprocal division, registered.
// ---------------------------------------------------------------------------
module gpg_div_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               lead_bit,
    input  wire logic               in_valid,
    input  wire logic [31:0]        in_rem,
    input  wire logic [32:0]        in_quot,
    input  wire gpg_pkg::div_word_t in_word,
    output logic                    out_valid,
    output logic [31:0]             out_rem,
    output logic [32:0]             out_quot,
    output gpg_pkg::div_word_t      out_word
);

    logic        valid_reg;
    logic [31:0] rem_reg;
    logic [32:0] quot_reg;
    gpg_pkg::div_word_t word_reg;

    logic [32:0] trial;
    logic        fits;
    logic [32:0] diff;

    // Shift in the next dividend bit and try the subtraction.
    always_comb
    begin
        trial = {in_rem, lead_bit};
        fits  = (trial >= {1'b0, in_word.dv});
        diff  = trial - {1'b0, in_word.dv};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= fits ? diff[31:0] : trial[31:0];
            quot_reg <= {in_quot[31:0], fits};
            word_reg <= in_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quot  = quot_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

// ===== src/grid_polynomial_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Grid polynomial generator core
// Evaluates a cubic (or its reciprocal) at an offset grid node, Q16.16.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle while the input is not stalled; the 33-cell divider chain is fully pipelined.
// The input stalls only while the output skid register holds a word.
// Reset clears configuration to its defaults and empties the pipeline.
module grid_polynomial_generator_core #(
    parameter int MAX_NODES  = 65536,
    parameter int MAX_DEGREE = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] node_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [31:0] node_value,
    output logic             saturated,
    output logic             zero_divide
);

    localparam int CELLS = 33;

    logic signed [31:0] coef_zero_reg, coef_one_reg, coef_two_reg, coef_three_reg;
    logic [30:0]        grid_step_reg;
    logic [1:0]         degree_reg;
    logic [16:0]        node_count_reg;
    logic [1:0]         shape_mode_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_zero_reg  <= '0;
            coef_one_reg   <= '0;
            coef_two_reg   <= '0;
            coef_three_reg <= '0;
            grid_step_reg  <= 31'd65536;
            degree_reg     <= 2'd3;
            node_count_reg <= 17'd65536;
            shape_mode_reg <= 2'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gpg_pkg::REG_COEF_ZERO:  coef_zero_reg  <= cfg_data;
                gpg_pkg::REG_COEF_ONE:   coef_one_reg   <= cfg_data;
                gpg_pkg::REG_COEF_TWO:   coef_two_reg   <= cfg_data;
                gpg_pkg::REG_COEF_THREE: coef_three_reg <= cfg_data;
                gpg_pkg::REG_GRID_STEP:  grid_step_reg  <= cfg_data[30:0];
                gpg_pkg::REG_DEGREE:     degree_reg     <= cfg_data[1:0];
                gpg_pkg::REG_NODE_COUNT: node_count_reg <= cfg_data[16:0];
                gpg_pkg::REG_SHAPE_MODE: shape_mode_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic skid_valid_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Polynomial pipeline.
    logic               front_valid;
    gpg_pkg::div_word_t front_word;

    gpg_poly_front #(
        .MAX_NODES  (MAX_NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_take    (in_valid && !in_stall),
        .node_index (node_index),
        .coef_zero  (coef_zero_reg),
        .coef_one   (coef_one_reg),
        .coef_two   (coef_two_reg),
        .coef_three (coef_three_reg),
        .grid_step  (grid_step_reg),
        .degree     (degree_reg),
        .node_count (node_count_reg),
        .shape_mode (shape_mode_reg),
        .out_valid  (front_valid),
        .out_word   (front_word)
    );

    // Reciprocal divider: one quotient bit per cell.
    logic               c_valid [CELLS+1];
    logic [31:0]        c_rem   [CELLS+1];
    logic [32:0]        c_quot  [CELLS+1];
    gpg_pkg::div_word_t c_word  [CELLS+1];

    assign c_valid[0] = front_valid;
    assign c_rem[0]   = '0;
    assign c_quot[0]  = '0;
    assign c_word[0]  = front_word;

    for (genvar j = 0; j < CELLS; j++)
    begin : g_cell
        gpg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .lead_bit  (j == 0),
            .in_valid  (c_valid[j]),
            .in_rem    (c_rem[j]),
            .in_quot   (c_quot[j]),
            .in_word   (c_word[j]),
            .out_valid (c_valid[j+1]),
            .out_rem   (c_rem[j+1]),
            .out_quot  (c_quot[j+1]),
            .out_word  (c_word[j+1])
        );
    end

    // Final selection of the result word.
    logic               h_valid_reg;
    logic signed [31:0] h_value_reg;
    logic               h_sat_reg, h_zdiv_reg;
    logic signed [31:0] r_value;
    logic               r_sat;
    gpg_pkg::div_word_t w;
    logic [32:0]        q;

    always_comb
    begin
        w       = c_word[CELLS];
        q       = c_quot[CELLS];
        r_value = w.pval;
        r_sat   = w.sat;
        if (w.recip)
        begin
            if (w.zdiv)
            begin
                r_value = 32'sh7FFFFFFF;
                r_sat   = 1'b1;
            end
            else if (!w.neg)
            begin
                if (q > 33'h07FFFFFFF)
                begin
                    r_value = 32'sh7FFFFFFF;
                    r_sat   = 1'b1;
                end
                else
                    r_value = q[31:0];
            end
            else
            begin
                if (q > 33'h080000000)
                begin
                    r_value = 32'sh80000000;
                    r_sat   = 1'b1;
                end
                else
                    r_value = 32'd0 - q[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (en)
            h_valid_reg <= c_valid[CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_value_reg <= r_value;
            h_sat_reg   <= r_sat;
            h_zdiv_reg  <= w.recip & w.zdiv;
        end
    end

    // Output register with skid stage.
    logic               out_valid_reg;
    logic signed [31:0] out_value_reg, skid_value_reg;
    logic               out_sat_reg, skid_sat_reg, out_zdiv_reg, skid_zdiv_reg;
    logic               take;
    assign take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (h_valid_reg)
        begin
            if (!out_valid_reg || take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_value_reg <= skid_value_reg;
                out_sat_reg   <= skid_sat_reg;
                out_zdiv_reg  <= skid_zdiv_reg;
            end
        end
        else if (h_valid_reg)
        begin
            if (!out_valid_reg || take)
            begin
                out_value_reg <= h_value_reg;
                out_sat_reg   <= h_sat_reg;
                out_zdiv_reg  <= h_zdiv_reg;
            end
            else
            begin
                skid_value_reg <= h_value_reg;
                skid_sat_reg   <= h_sat_reg;
                skid_zdiv_reg  <= h_zdiv_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign node_value  = out_value_reg;
    assign saturated   = out_sat_reg;
    assign zero_divide = out_zdiv_reg;

endmodule
`default_nettype wire

// ===== src/gpg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "grid_polynomial_generator_core_defines.svh"
// ---------------------------------------------------------------------------
// Port checker
// Watches the top-level ports of the generator over time.
// ---------------------------------------------------------------------------
module gpg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] node_value,
    input wire logic        saturated,
    input wire logic        zero_divide
);

    // A zero denominator always reports clipping.
    `GPG_ASSERT_NOW(a_zdiv_sat, clk, rst_n, out_valid && zero_divide, saturated)

    // A zero denominator gives the largest positive value.
    `GPG_ASSERT_NOW(a_zdiv_val, clk, rst_n, out_valid && zero_divide, node_value == 32'h7FFFFFFF)

    // A stalled word is held.
    `GPG_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)

    // A stalled word keeps its value.
    `GPG_ASSERT_NEXT(a_hold_data, clk, rst_n, out_valid && out_stall, $stable(node_value))

endmodule

bind grid_polynomial_generator_core gpg_checker u_gpg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .node_value  (node_value),
    .saturated   (saturated),
    .zero_divide (zero_divide)
);
`default_nettype wire
